// File: rtl/lottery_draw_scheduler_top_defines.svh
// Assertion macros for the lottery draw scheduler.
`ifndef LOTTERY_DRAW_SCHEDULER_TOP_DEFINES_SVH
`define LOTTERY_DRAW_SCHEDULER_TOP_DEFINES_SVH
// Implication check, disabled while in reset.
`define LDS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lds check failed");
// Next-cycle implication check, disabled while in reset.
`define LDS_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lds check failed");
`endif

// File: rtl/lds_pkg.sv
// Package: types, codes and constants of the lottery draw scheduler.
`timescale 1ns / 1ps
package lds_pkg;
    localparam int MAX_JOBS_DEF = 64;
    localparam int TOT_W = 15;
    localparam int OCC_W = 7;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DRAWN    = 2'd1,
        ST_NONE     = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_SUM_RD, S_SUM, S_DIV, S_WALK_RD, S_WALK,
        S_SHIFT_RD, S_SHIFT, S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic write_ins;
        logic clr_idx;
        logic inc_idx;
        logic acc_sum;
        logic div_step;
        logic walk_step;
        logic shift_wr;
        logic dec_count;
        logic done;
    } cmd_t;

    // Status back from the datapath.
    typedef struct packed {
        logic kind;
        logic full;
        logic empty;
        logic idx_end;
        logic total_zero;
        logic div_done;
        logic found;
        logic shift_end;
    } sts_t;
endpackage

// File: rtl/lds_ram.sv
// Generic single-port write, single-port registered-read RAM.
`timescale 1ns / 1ps
module lds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/lds_ctrl.sv
// Controller state machine of the lottery draw scheduler.
`timescale 1ns / 1ps
module lds_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  lds_pkg::sts_t  sts,
    output logic           busy,
    output lds_pkg::cmd_t  cmd
);
    import lds_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                if (sts.kind)
                begin
                    state_next = sts.empty ? S_DONE : S_SUM_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SUM_RD:   state_next = S_SUM;
            S_SUM:      state_next = sts.idx_end ? S_DIV : S_SUM_RD;
            S_DIV:
            begin
                if (sts.total_zero)
                begin
                    state_next = S_DONE;
                end
                else if (sts.div_done)
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:  state_next = S_WALK;
            S_WALK:
            begin
                if (sts.found)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = sts.idx_end ? S_DONE : S_WALK_RD;
                end
            end
            S_SHIFT_RD: state_next = sts.shift_end ? S_DONE : S_SHIFT;
            S_SHIFT:    state_next = S_SHIFT_RD;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_INS:
            begin
                cmd.clr_idx = 1'b1;
                cmd.write_ins = !sts.kind && !sts.full;
            end
            S_SUM_RD:   ;
            S_SUM:
            begin
                cmd.acc_sum = 1'b1;
                cmd.inc_idx = !sts.idx_end;
                cmd.clr_idx = sts.idx_end;
            end
            S_DIV:      cmd.div_step = !sts.total_zero;
            S_WALK_RD:  ;
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                cmd.inc_idx = 1'b1;
            end
            S_SHIFT_RD: cmd.dec_count = sts.shift_end;
            S_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                cmd.inc_idx = 1'b1;
            end
            S_DONE:     cmd.done = 1'b1;
            default:    ;
        endcase
    end
endmodule

// File: rtl/lds_dp.sv
// Datapath of the lottery draw scheduler: table, sums, modulo unit, walk.
`timescale 1ns / 1ps
module lds_dp #(
    parameter int MAX_JOBS = lds_pkg::MAX_JOBS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lds_pkg::cmd_t              cmd,
    output lds_pkg::sts_t              sts,
    input  logic                       kind,
    input  logic [15:0]                job_id,
    input  logic [7:0]                 job_priority,
    input  logic [31:0]                job_arrival,
    input  logic [31:0]                current_time,
    input  logic [31:0]                random_word,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [15:0]                winner_id,
    output logic [7:0]                 winner_priority,
    output logic [31:0]                winner_arrival,
    output logic [lds_pkg::TOT_W-1:0]  total_tickets,
    output logic [lds_pkg::OCC_W-1:0]  occupancy
);
    import lds_pkg::*;

    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int SW = $clog2(MAX_JOBS * 256 + 1);

    logic          kind_reg;
    logic [15:0]   id_reg;
    logic [7:0]    pri_reg;
    logic [31:0]   arr_reg, now_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [SW-1:0] total_reg, sum_reg;
    logic          found_reg;
    logic          full_seen_reg;
    logic [15:0]   wid_reg;
    logic [7:0]    wpri_reg;
    logic [31:0]   warr_reg;

    // Restoring modulo unit state
    logic [SW-1:0] rem_reg;
    logic [31:0]   quo_reg;
    logic [4:0]    dcnt_reg;

    logic [15:0]   rd_id;
    logic [7:0]    rd_pri;
    logic [31:0]   rd_arr;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wd_id;
    logic [7:0]    wd_pri;
    logic [31:0]   wd_arr;
    logic          elig;
    logic          hit;
    logic [SW-1:0] tix, sum_new;
    logic [SW:0]   rem_sh;

    assign elig = (rd_arr <= now_reg);
    assign tix = SW'(rd_pri) + SW'(1);
    assign sum_new = sum_reg + tix;
    assign hit = elig && (sum_new > rem_reg);
    assign rem_sh = {rem_reg, quo_reg[31]};

    // Table write and read addressing
    always_comb
    begin
        we = cmd.write_ins || cmd.shift_wr;
        waddr = cmd.write_ins ? count_reg[AW-1:0] : AW'(idx_reg - CW'(1));
        wd_id = cmd.write_ins ? id_reg : rd_id;
        wd_pri = cmd.write_ins ? pri_reg : rd_pri;
        wd_arr = cmd.write_ins ? arr_reg : rd_arr;
        raddr = idx_reg[AW-1:0];
    end

    lds_ram #(.WIDTH(16), .DEPTH(MAX_JOBS)) u_ram_id (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wd_id), .raddr(raddr), .rdata(rd_id));
    lds_ram #(.WIDTH(8), .DEPTH(MAX_JOBS)) u_ram_pri (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wd_pri), .raddr(raddr), .rdata(rd_pri));
    lds_ram #(.WIDTH(32), .DEPTH(MAX_JOBS)) u_ram_arr (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wd_arr), .raddr(raddr), .rdata(rd_arr));

    // Status to the controller
    always_comb
    begin
        sts.kind = kind_reg;
        sts.full = (count_reg >= CW'(MAX_JOBS));
        sts.empty = (count_reg == '0);
        sts.idx_end = ((idx_reg + CW'(1)) >= count_reg);
        sts.total_zero = (total_reg == '0);
        sts.div_done = (dcnt_reg == 5'd31);
        sts.found = hit;
        sts.shift_end = (idx_reg >= count_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg <= '0;
            dcnt_reg <= '0;
            found_reg <= 1'b0;
            full_seen_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_ins)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.dec_count)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.clr_idx)
            begin
                idx_reg <= '0;
            end
            else if (cmd.inc_idx)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.load)
            begin
                found_reg <= 1'b0;
                dcnt_reg <= '0;
                full_seen_reg <= (count_reg >= CW'(MAX_JOBS)) && !kind;
            end
            else
            begin
                if (cmd.div_step)
                begin
                    dcnt_reg <= dcnt_reg + 5'd1;
                end
                if (cmd.walk_step && hit)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            id_reg <= job_id;
            pri_reg <= job_priority;
            arr_reg <= job_arrival;
            now_reg <= current_time;
            total_reg <= '0;
            sum_reg <= '0;
            rem_reg <= '0;
            quo_reg <= random_word;
            wid_reg <= '0;
            wpri_reg <= '0;
            warr_reg <= '0;
        end
        else
        begin
            // Eligible ticket total
            if (cmd.acc_sum && elig)
            begin
                total_reg <= total_reg + tix;
            end
            // One quotient bit a cycle; only the remainder is kept
            if (cmd.div_step)
            begin
                if (rem_sh >= {1'b0, total_reg})
                begin
                    rem_reg <= SW'(rem_sh - {1'b0, total_reg});
                end
                else
                begin
                    rem_reg <= rem_sh[SW-1:0];
                end
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            // Running sum of the winner walk
            if (cmd.walk_step && elig)
            begin
                sum_reg <= sum_new;
                if (hit)
                begin
                    wid_reg <= rd_id;
                    wpri_reg <= rd_pri;
                    warr_reg <= rd_arr;
                end
            end
        end
    end

    // Result strobe and fields
    always_comb
    begin
        done = cmd.done;
        if (!kind_reg)
        begin
            status = full_seen_reg ? ST_FULL : ST_INSERTED;
        end
        else
        begin
            status = found_reg ? ST_DRAWN : ST_NONE;
        end
        winner_id = wid_reg;
        winner_priority = wpri_reg;
        winner_arrival = warr_reg;
        total_tickets = kind_reg ? TOT_W'(total_reg) : '0;
        occupancy = OCC_W'(count_reg);
    end
endmodule

// File: rtl/lottery_draw_scheduler_top.sv
// Insert: after start is accepted the controller passes S_INS and S_DONE, then returns to idle.
// Draw over N jobs: sum walk, 32-step modulo, winner walk and, when a winner is found, compaction;
// each entry is read through the registered-read RAM in a read state and then a step state.
// A new transaction is accepted only in the idle state, after done for the previous one.
// rst_n clears the controller and the job count; table contents are not cleared.
// The receiver cannot stall: done marks each result for exactly one cycle.
`timescale 1ns / 1ps
module lottery_draw_scheduler_top #(
    parameter int MAX_JOBS = lds_pkg::MAX_JOBS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       kind,
    input  logic [15:0]                job_id,
    input  logic [7:0]                 job_priority,
    input  logic [31:0]                job_arrival,
    input  logic [31:0]                current_time,
    input  logic [31:0]                random_word,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [15:0]                winner_id,
    output logic [7:0]                 winner_priority,
    output logic [31:0]                winner_arrival,
    output logic [lds_pkg::TOT_W-1:0]  total_tickets,
    output logic [lds_pkg::OCC_W-1:0]  occupancy
);
    import lds_pkg::*;
`include "lottery_draw_scheduler_top_defines.svh"

    cmd_t cmd;
    sts_t sts;

    lds_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd));

    lds_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .kind(kind), .job_id(job_id), .job_priority(job_priority),
        .job_arrival(job_arrival), .current_time(current_time),
        .random_word(random_word), .done(done), .status(status),
        .winner_id(winner_id), .winner_priority(winner_priority),
        .winner_arrival(winner_arrival), .total_tickets(total_tickets),
        .occupancy(occupancy));

    `LDS_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    `LDS_ASSERT_NXT(a_done_idle, clk, rst_n, done, !busy)
    `LDS_ASSERT_IMP(a_full_zero, clk, rst_n, done && status == ST_FULL, winner_id == '0)
endmodule

// File: tb/sv/lottery_draw_scheduler_top_tb.sv
// Testbench for the lottery draw scheduler: directed table, fill to overflow, then random traffic.
`timescale 1ns / 1ps
module lottery_draw_scheduler_top_tb;
    import lds_pkg::*;

    localparam int JOBS = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic [15:0] job_id;
    logic [7:0]  job_priority;
    logic [31:0] job_arrival;
    logic [31:0] current_time;
    logic [31:0] random_word;
    logic        done;
    logic [1:0]  status;
    logic [15:0] winner_id;
    logic [7:0]  winner_priority;
    logic [31:0] winner_arrival;
    logic [TOT_W-1:0] total_tickets;
    logic [OCC_W-1:0] occupancy;

    lottery_draw_scheduler_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .job_id(job_id), .job_priority(job_priority),
        .job_arrival(job_arrival), .current_time(current_time),
        .random_word(random_word), .done(done), .status(status),
        .winner_id(winner_id), .winner_priority(winner_priority),
        .winner_arrival(winner_arrival), .total_tickets(total_tickets),
        .occupancy(occupancy)
    );

    typedef struct packed {
        logic        kind;
        logic [15:0] id;
        logic [7:0]  pri;
        logic [31:0] arr;
        logic [31:0] now;
        logic [31:0] rnd;
    } job_cmd_t;

    typedef struct packed {
        status_t          st;
        logic [15:0]      id;
        logic [7:0]       pri;
        logic [31:0]      arr;
        logic [TOT_W-1:0] tot;
        logic [OCC_W-1:0] occ;
    } draw_res_t;

    // Row of the directed table; fixed expectation applies only when has_exp.
    typedef struct {
        job_cmd_t  cmd;
        bit        has_exp;
        draw_res_t exp;
    } dir_row_t;

    // Shadow copy of the ready table
    logic [15:0] sh_id[JOBS];
    logic [7:0]  sh_pri[JOBS];
    logic [31:0] sh_arr[JOBS];
    int          sh_count;

    draw_res_t pending_q[$];
    int  errors;
    int  n_results;
    int  n_drawn;
    int  n_full;
    int  n_none;
    longint cycles;
    int  send_idle_pct;

    // Expected result of one transaction; updates the shadow table
    function automatic draw_res_t schedule_job(job_cmd_t c);
        draw_res_t r;
        longint total;
        longint ticket;
        longint sum;
        int pick;
        r = '0;
        total = 0;
        pick = -1;
        if (c.kind == 1'b0) begin
            if (sh_count >= JOBS) begin
                r.st = ST_FULL;
            end
            else begin
                sh_id[sh_count] = c.id;
                sh_pri[sh_count] = c.pri;
                sh_arr[sh_count] = c.arr;
                sh_count++;
                r.st = ST_INSERTED;
            end
        end
        else begin
            for (int i = 0; i < sh_count; i++)
                if (sh_arr[i] <= c.now) total += sh_pri[i] + 1;
            r.st = ST_NONE;
            if (total != 0) begin
                ticket = longint'(c.rnd) % total;
                sum = 0;
                for (int i = 0; i < sh_count && pick < 0; i++) begin
                    if (sh_arr[i] <= c.now) begin
                        sum += sh_pri[i] + 1;
                        if (sum > ticket) pick = i;
                    end
                end
                r.st = ST_DRAWN;
                r.id = sh_id[pick];
                r.pri = sh_pri[pick];
                r.arr = sh_arr[pick];
                for (int i = pick; i + 1 < sh_count; i++) begin
                    sh_id[i] = sh_id[i + 1];
                    sh_pri[i] = sh_pri[i + 1];
                    sh_arr[i] = sh_arr[i + 1];
                end
                sh_count--;
            end
            r.tot = total[TOT_W-1:0];
        end
        r.occ = sh_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH result %0d %s: got %0h expected %0h", n_results, what, got, want);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Result checker
    initial
    begin
        draw_res_t e;
        errors = 0;
        n_results = 0;
        n_drawn = 0;
        n_full = 0;
        n_none = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && done === 1'b1)
            begin
                if (pending_q.size() == 0)
                begin
                    report_mismatch("unexpected result status", status, 0);
                end
                else
                begin
                    e = pending_q.pop_front();
                    if (status !== e.st) report_mismatch("status", status, e.st);
                    if (winner_id !== e.id) report_mismatch("winner_id", winner_id, e.id);
                    if (winner_priority !== e.pri)
                        report_mismatch("winner_priority", winner_priority, e.pri);
                    if (winner_arrival !== e.arr)
                        report_mismatch("winner_arrival", winner_arrival, e.arr);
                    if (total_tickets !== e.tot)
                        report_mismatch("total_tickets", total_tickets, e.tot);
                    if (occupancy !== e.occ) report_mismatch("occupancy", occupancy, e.occ);
                    case (e.st)
                        ST_DRAWN: n_drawn++;
                        ST_FULL:  n_full++;
                        ST_NONE:  n_none++;
                        default: ;
                    endcase
                end
                n_results++;
            end
        end
    end

    // Present one transaction and hold it until the scheduler is idle again
    task automatic issue(input job_cmd_t c, input bit has_exp, input draw_res_t fixed);
        draw_res_t p;
        @(posedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        start <= 1'b1;
        kind <= c.kind;
        job_id <= c.id;
        job_priority <= c.pri;
        job_arrival <= c.arr;
        current_time <= c.now;
        random_word <= c.rnd;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        p = schedule_job(c);
        if (has_exp && p != fixed)
            report_mismatch("directed row status", p.st, fixed.st);
        pending_q.insert(pending_q.size(), p);
        start <= 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic job_cmd_t mk(bit k, int id, int pri, logic [31:0] arr,
                                    logic [31:0] now, logic [31:0] rnd);
        job_cmd_t c;
        c.kind = k;
        c.id = id[15:0];
        c.pri = pri[7:0];
        c.arr = arr;
        c.now = now;
        c.rnd = rnd;
        return c;
    endfunction

    function automatic draw_res_t rs(status_t st, int id, int pri, logic [31:0] arr,
                                     int tot, int occ);
        draw_res_t r;
        r.st = st;
        r.id = id[15:0];
        r.pri = pri[7:0];
        r.arr = arr;
        r.tot = tot[TOT_W-1:0];
        r.occ = occ[OCC_W-1:0];
        return r;
    endfunction

    // Random job with arrival spread either narrow or across the full range
    function automatic job_cmd_t rand_job(bit k, logic [31:0] base);
        job_cmd_t c;
        c.kind = k;
        c.id = 16'($urandom);
        c.pri = ($urandom_range(3) == 0) ? 8'hff : 8'($urandom);
        c.arr = ($urandom_range(7) == 0) ? $urandom : base + $urandom_range(200);
        c.now = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(250);
        c.rnd = $urandom;
        return c;
    endfunction

    // Stimulus
    initial
    begin
        dir_row_t dir[$];
        job_cmd_t c;
        logic [31:0] base;
        int n_items;
        int fill;

        rst_n = 1'b0;
        start = 1'b0;
        kind = 1'b0;
        job_id = '0;
        job_priority = '0;
        job_arrival = '0;
        current_time = '0;
        random_word = '0;
        sh_count = 0;
        send_idle_pct = 0;
        n_items = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty draw, extremes, unsigned compare, single winner
        dir.insert(dir.size(), '{mk(1, 0, 0, 0, 32'hffffffff, 32'hffffffff), 1,
                                 rs(ST_NONE, 0, 0, 0, 0, 0)});
        dir.insert(dir.size(), '{mk(0, 16'hffff, 255, 32'hffffffff, 0, 0), 1,
                                 rs(ST_INSERTED, 0, 0, 0, 0, 1)});
        dir.insert(dir.size(), '{mk(1, 0, 0, 0, 32'hfffffffe, 5), 1,
                                 rs(ST_NONE, 0, 0, 0, 0, 1)});
        dir.insert(dir.size(), '{mk(1, 0, 0, 0, 32'hffffffff, 32'hffffffff), 1,
                                 rs(ST_DRAWN, 16'hffff, 255, 32'hffffffff, 256, 0)});
        dir.insert(dir.size(), '{mk(0, 0, 0, 0, 0, 0), 1, rs(ST_INSERTED, 0, 0, 0, 0, 1)});
        dir.insert(dir.size(), '{mk(0, 16'h1234, 3, 10, 0, 0), 1,
                                 rs(ST_INSERTED, 0, 0, 0, 0, 2)});
        dir.insert(dir.size(), '{mk(0, 16'h5678, 7, 32'h80000000, 0, 0), 1,
                                 rs(ST_INSERTED, 0, 0, 0, 0, 3)});
        dir.insert(dir.size(), '{mk(1, 0, 0, 0, 10, 4), 0, '0});
        dir.insert(dir.size(), '{mk(1, 0, 0, 0, 32'h7fffffff, 0), 0, '0});
        dir.insert(dir.size(), '{mk(1, 0, 0, 0, 32'h80000000, 32'hffffffff), 0, '0});
        dir.insert(dir.size(), '{mk(1, 0, 0, 0, 32'hffffffff, 0), 0, '0});
        foreach (dir[i])
            issue(dir[i].cmd, dir[i].has_exp, dir[i].exp);
        n_items += dir.size();
        drain();

        // Fill the table to overflow: full reports and a draw from a full table
        fill = 0;
        while (sh_count < JOBS)
        begin
            issue(mk(0, fill, fill * 4, fill, 0, 0), 0, '0);
            fill++;
        end
        issue(mk(0, 16'haaaa, 1, 0, 0, 0), 1, rs(ST_FULL, 0, 0, 0, 0, JOBS));
        issue(mk(0, 16'h5555, 2, 1, 0, 0), 1, rs(ST_FULL, 0, 0, 0, 0, JOBS));
        issue(mk(1, 0, 0, 0, 32'hffffffff, 32'hffffffff), 0, '0);
        n_items += fill + 3;
        drain();

        // Random part in three idling phases
        base = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 55 : 0;
            for (int k = 0; k < 530; k++)
            begin
                // Bias inserts while the table is short, draws when long
                c = rand_job($urandom_range(JOBS) < sh_count + 8 ? 1 : 0, base);
                issue(c, 0, '0);
                base += $urandom_range(3);
                if ($urandom_range(15) == 0) base = $urandom;
                n_items++;
            end
            // Wait for every outstanding result before the next phase
            drain();
        end

        repeat (4 * JOBS + 60) @(posedge clk);
        $display("covered %0d transactions: %0d draws won, %0d empty draws, %0d full tables",
                 n_items, n_drawn, n_none, n_full);
        if (errors == 0 && pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
